### hdl/encoder_lut_corrected_angle_core_assert.svh
// Assertion macros shared by the checker of the encoder angle core.
`ifndef ENCODER_LUT_CORRECTED_ANGLE_CORE_ASSERT_SVH
`define ENCODER_LUT_CORRECTED_ANGLE_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ELCA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ELCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/elca_pkg.sv
// Shared types and constants of the encoder angle core.
package elca_pkg;

  localparam int POS_BITS    = 18;
  localparam int FRAC_BITS   = 11;
  localparam int TBL_AW      = POS_BITS - FRAC_BITS;
  localparam int TBL_DEPTH   = 1 << TBL_AW;
  localparam int TBL_W       = 16;
  localparam int CPR_W       = POS_BITS + 1;
  localparam int DELTA_W     = POS_BITS + 1;
  localparam int ACC_W       = 32;
  localparam int POLE_W      = 7;
  localparam int MOD_DW      = POS_BITS + 2;
  localparam int PROD_W      = TBL_W + FRAC_BITS + 2;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 112;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CPR_W-1:0] CPR_FULL = {1'b1, {POS_BITS{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CPR  = 2'd0,
    REG_REV  = 2'd1,
    REG_ZOFF = 2'd2,
    REG_POLE = 2'd3
  } elca_reg_e;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_TBL_WR = 1'b1
  } elca_func_e;

  typedef struct packed {
    logic [CPR_W-1:0]    cpr;
    logic                rev;
    logic [POS_BITS-1:0] zoff;
    logic [POLE_W-1:0]   pole;
  } elca_cfg_t;

  typedef struct packed {
    elca_func_e          func;
    logic [POS_BITS-1:0] raw;
    logic [TBL_AW-1:0]   tidx;
    logic [TBL_W-1:0]    tval;
  } elca_item_t;

  typedef struct packed {
    logic [POS_BITS-1:0] elec;
    logic [POS_BITS-1:0] mech;
    logic [ACC_W-1:0]    acc;
    logic [DELTA_W-1:0]  delta;
    logic [POS_BITS-1:0] count;
  } elca_result_t;

endpackage

### hdl/elca_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module elca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/elca_fifo.sv
// Short queue of classified items between the front end and the back end.
module elca_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  elca_pkg::elca_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output elca_pkg::elca_item_t head_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  elca_pkg::elca_item_t mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q;
  logic [PTR_W-1:0] rptr_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  assign head_o  = mem_q[rptr_q];
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

### hdl/elca_front.sv
// Front end: accepts input transfers, assembles and orients the position, classifies items.
module elca_front (
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // Fields from bit 0: reply_byte0, reply_byte1, reply_byte2, table_index, table_value.
  input  logic [elca_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // Fields from bit 0: func.
  input  logic                                s_axis_tuser_i,
  input  elca_pkg::elca_cfg_t                 cfg_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output elca_pkg::elca_item_t                q_item_o
);

  logic [7:0]                    byte0;
  logic [7:0]                    byte1;
  logic [7:0]                    byte2;
  logic [elca_pkg::POS_BITS-1:0] pos;
  logic [elca_pkg::CPR_W-1:0]    flip;

  assign byte0 = s_axis_tdata_i[7:0];
  assign byte1 = s_axis_tdata_i[15:8];
  assign byte2 = s_axis_tdata_i[23:16];
  assign pos   = {byte0, byte1[7:2], byte2[7:4]};
  assign flip  = cfg_i.cpr - {1'b0, pos};

  always_comb begin
    q_item_o.func = elca_pkg::elca_func_e'(s_axis_tuser_i);
    q_item_o.raw  = cfg_i.rev ? flip[elca_pkg::POS_BITS-1:0] : pos;
    q_item_o.tidx = s_axis_tdata_i[30:24];
    q_item_o.tval = s_axis_tdata_i[46:31];
  end

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

endmodule

### hdl/elca_mod.sv
// Bit-serial true modulo unit: signed operand modulo a positive modulus, one bit per cycle.
module elca_mod #(
  parameter int DW = 20,
  parameter int MW = 19
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] a_i,
  input  logic [MW-1:0] m_i,
  output logic          done_o,
  output logic [MW-1:0] rem_o
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    mag_q;
  logic [MW-1:0]    rem_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [MW:0]      trial;
  logic [MW:0]      trial_sub;
  logic             fit;

  assign trial     = {rem_q, mag_q[DW-1]};
  assign fit       = (trial >= {1'b0, m_i});
  assign trial_sub = trial - {1'b0, m_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DW);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end else begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[DW-1];
      mag_q <= a_i[DW-1] ? (~a_i + 1'b1) : a_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        rem_q <= fit ? trial_sub[MW-1:0] : trial[MW-1:0];
        mag_q <= mag_q << 1;
      end else if (neg_q && (rem_q != '0)) begin
        rem_q <= m_i - rem_q;
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### hdl/elca_back.sv
// Back end: table writes, interpolated correction, wrapping, accumulation and angle output.
module elca_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  elca_pkg::elca_cfg_t    cfg_i,
  input  logic                   q_empty_i,
  input  elca_pkg::elca_item_t   q_head_i,
  output logic                   q_pop_o,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output elca_pkg::elca_result_t res_o
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_RD_HI = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_SUB   = 8'b0000_1000,
    ST_MOD1  = 8'b0001_0000,
    ST_ACC   = 8'b0010_0000,
    ST_MOD2  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } elca_state_e;

  elca_state_e state_q;
  elca_state_e state_d;

  logic [elca_pkg::POS_BITS-1:0]        raw_q;
  logic [elca_pkg::TBL_W-1:0]           lo_q;
  logic signed [elca_pkg::PROD_W-1:0]   prod_q;
  logic signed [elca_pkg::PROD_W-1:0]   prod_d;
  logic signed [elca_pkg::TBL_W:0]      diff;
  logic signed [elca_pkg::FRAC_BITS:0]  frac_s;
  logic [elca_pkg::POS_BITS-1:0]        count_q;
  logic [elca_pkg::POS_BITS-1:0]        prev_q;
  logic [elca_pkg::ACC_W-1:0]           acc_q;
  logic [elca_pkg::DELTA_W-1:0]         delta_q;
  logic [elca_pkg::DELTA_W-1:0]         delta_d;
  logic [elca_pkg::MOD_DW-1:0]          corr_val;
  logic [elca_pkg::MOD_DW-1:0]          cali_val;
  logic [elca_pkg::MOD_DW-1:0]          mod_a;
  logic                                 mod_start;
  logic                                 mod_done;
  logic [elca_pkg::CPR_W-1:0]           mod_rem;
  logic [elca_pkg::POS_BITS-1:0]        rem_pos;
  logic [elca_pkg::POLE_W+elca_pkg::POS_BITS-1:0] elec_full;
  logic                                 ram_we;
  logic [elca_pkg::TBL_AW-1:0]          rd_addr;
  logic [elca_pkg::TBL_W-1:0]           rd_data;
  logic                                 res_valid_q;
  elca_pkg::elca_result_t               res_q;
  logic                                 load;

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;
  assign ram_we  = q_pop_o && (q_head_i.func == elca_pkg::FUNC_TBL_WR);
  assign rd_addr = (state_q == ST_RD_HI)
                 ? elca_pkg::TBL_AW'(raw_q[elca_pkg::POS_BITS-1 -: elca_pkg::TBL_AW] + 1'b1)
                 : q_head_i.raw[elca_pkg::POS_BITS-1 -: elca_pkg::TBL_AW];

  elca_ram #(
    .WIDTH (elca_pkg::TBL_W),
    .DEPTH (elca_pkg::TBL_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_head_i.tidx),
    .wdata_i (q_head_i.tval),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign diff   = $signed({rd_data[elca_pkg::TBL_W-1], rd_data})
                - $signed({lo_q[elca_pkg::TBL_W-1], lo_q});
  assign frac_s = $signed({1'b0, raw_q[elca_pkg::FRAC_BITS-1:0]});
  assign prod_d = diff * frac_s;

  assign corr_val = elca_pkg::MOD_DW'(raw_q)
                  - elca_pkg::MOD_DW'($signed(lo_q))
                  - elca_pkg::MOD_DW'($signed(prod_q[elca_pkg::PROD_W-1:elca_pkg::FRAC_BITS]));
  assign cali_val = elca_pkg::MOD_DW'(count_q) - elca_pkg::MOD_DW'(cfg_i.zoff);

  assign mod_start = (state_q == ST_SUB) || (state_q == ST_ACC);
  assign mod_a     = (state_q == ST_SUB) ? corr_val : cali_val;

  elca_mod #(
    .DW (elca_pkg::MOD_DW),
    .MW (elca_pkg::CPR_W)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .a_i     (mod_a),
    .m_i     (cfg_i.cpr),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign rem_pos   = mod_rem[elca_pkg::POS_BITS-1:0];
  assign delta_d   = {1'b0, count_q} - {1'b0, prev_q};
  assign elec_full = cfg_i.pole * rem_pos;
  assign load      = (state_q == ST_OUT) && (!res_valid_q || res_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_pop_o && (q_head_i.func == elca_pkg::FUNC_SAMPLE)) begin
          state_d = ST_RD_HI;
        end
      end
      ST_RD_HI: state_d = ST_MUL;
      ST_MUL:   state_d = ST_SUB;
      ST_SUB:   state_d = ST_MOD1;
      ST_MOD1: begin
        if (mod_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC:   state_d = ST_MOD2;
      ST_MOD2: begin
        if (mod_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      acc_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ACC) begin
        prev_q <= count_q;
        acc_q  <= acc_q + elca_pkg::ACC_W'($signed(delta_d));
      end
      if (load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      raw_q <= q_head_i.raw;
    end
    if (state_q == ST_RD_HI) begin
      lo_q <= rd_data;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
    end
    if ((state_q == ST_MOD1) && mod_done) begin
      count_q <= rem_pos;
    end
    if (state_q == ST_ACC) begin
      delta_q <= delta_d;
    end
    if (load) begin
      res_q.count <= count_q;
      res_q.delta <= delta_q;
      res_q.acc   <= acc_q;
      res_q.mech  <= rem_pos;
      res_q.elec  <= elec_full[elca_pkg::POS_BITS-1:0];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### hdl/encoder_lut_corrected_angle_core.sv
// Top level of the linearized encoder angle core: config registers, front end, queue, back end.
// The back end takes one sample at a time, its pace set by two passes through the bit-serial
// modulo unit (20 steps each); the queue accepts further transfers while it is not full.
// A table write is performed when its item is popped from the queue.
// Reset: rst_ni sets the config registers to their defaults and clears previous count and
// accumulator; table entries are unset.
module encoder_lut_corrected_angle_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [elca_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [elca_pkg::CPR_W-1:0]         cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // Fields from bit 0: reply_byte0, reply_byte1, reply_byte2, table_index, table_value.
  input  logic [elca_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // Fields from bit 0: func.
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // Fields from bit 0: corrected_count, count_delta, accumulated_count, mech_angle,
  // electrical_angle.
  output logic [elca_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  logic [elca_pkg::CPR_W-1:0]    cpr_q;
  logic                          rev_q;
  logic [elca_pkg::POS_BITS-1:0] zoff_q;
  logic [elca_pkg::POLE_W-1:0]   pole_q;
  elca_pkg::elca_cfg_t           cfg;
  elca_pkg::elca_item_t          push_item;
  elca_pkg::elca_item_t          head_item;
  elca_pkg::elca_result_t        res;
  logic                          q_push;
  logic                          q_pop;
  logic                          q_full;
  logic                          q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q  <= elca_pkg::CPR_FULL;
      rev_q  <= 1'b0;
      zoff_q <= '0;
      pole_q <= elca_pkg::POLE_W'(1);
    end else if (cfg_we_i) begin
      case (elca_pkg::elca_reg_e'(cfg_idx_i))
        elca_pkg::REG_CPR:  cpr_q  <= cfg_data_i;
        elca_pkg::REG_REV:  rev_q  <= cfg_data_i[0];
        elca_pkg::REG_ZOFF: zoff_q <= cfg_data_i[elca_pkg::POS_BITS-1:0];
        elca_pkg::REG_POLE: pole_q <= cfg_data_i[elca_pkg::POLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cpr_q == '0) begin
      cfg.cpr = elca_pkg::CPR_W'(1);
    end else if (cpr_q > elca_pkg::CPR_FULL) begin
      cfg.cpr = elca_pkg::CPR_FULL;
    end else begin
      cfg.cpr = cpr_q;
    end
    cfg.rev  = rev_q;
    cfg.zoff = zoff_q;
    cfg.pole = pole_q;
  end

  elca_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_i           (cfg),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (push_item)
  );

  elca_fifo #(
    .DEPTH (elca_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (head_item)
  );

  elca_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_head_i    (head_item),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = elca_pkg::OUT_TDATA_W'({res.elec, res.mech, res.acc, res.delta,
                                                   res.count});

endmodule

### hdl/elca_chk.sv
// Port-level checker of the encoder angle core and its bind to the top level.
`include "encoder_lut_corrected_angle_core_assert.svh"

module elca_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [elca_pkg::OUT_TDATA_W-1:0] out_data_i
);

  logic [elca_pkg::POS_BITS-1:0] out_count;
  logic [elca_pkg::DELTA_W-1:0]  out_delta;
  logic [elca_pkg::ACC_W-1:0]    out_acc;
  logic [elca_pkg::POS_BITS-1:0] prev_count_q;
  logic [elca_pkg::ACC_W-1:0]    prev_acc_q;
  logic [elca_pkg::DELTA_W-1:0]  exp_delta;
  logic [elca_pkg::ACC_W-1:0]    exp_acc;

  assign out_count = out_data_i[17:0];
  assign out_delta = out_data_i[36:18];
  assign out_acc   = out_data_i[68:37];
  assign exp_delta = {1'b0, out_count} - {1'b0, prev_count_q};
  assign exp_acc   = prev_acc_q + elca_pkg::ACC_W'($signed(out_delta));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q <= '0;
      prev_acc_q   <= '0;
    end else if (out_valid_i && out_ready_i) begin
      prev_count_q <= out_count;
      prev_acc_q   <= out_acc;
    end
  end

  `ELCA_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result changed")
  `ELCA_ASSERT_SAME(a_delta_chain, out_valid_i, out_delta == exp_delta, "count_delta does not match previous count")
  `ELCA_ASSERT_SAME(a_acc_chain, out_valid_i, out_acc == exp_acc, "accumulated_count does not follow count_delta")

endmodule

bind encoder_lut_corrected_angle_core elca_chk u_elca_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (m_axis_tvalid_o),
  .out_ready_i (m_axis_tready_i),
  .out_data_i  (m_axis_tdata_o)
);
